FILE: src/console_cpu_bus_decoder_core_macros.svh
// assertion macros for the bus decoder core
`ifndef CONSOLE_CPU_BUS_DECODER_CORE_MACROS_SVH
`define CONSOLE_CPU_BUS_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CBD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CBD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CBD_ASSERT(lbl, prop, msg)
`define CBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/cbd_pkg.sv
`timescale 1ns / 1ps
package cbd_pkg;

   localparam int RAM_DEPTH_DEF = 2048;

   // ram index split: a 13-bit ram window, reciprocal scaled by 2^26
   localparam int RAM_WIN_W    = 13;
   localparam int RECIP_SHIFT  = 26;
   localparam int QUOT_W       = 32 - RECIP_SHIFT;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CHEAT_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHEAT_ADDRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHEAT_VALUE   = 2'd2;

   localparam logic [2:0] T_RAM   = 3'd0;
   localparam logic [2:0] T_PPU   = 3'd1;
   localparam logic [2:0] T_APU   = 3'd2;
   localparam logic [2:0] T_CTRL  = 3'd3;
   localparam logic [2:0] T_CART  = 3'd4;
   localparam logic [2:0] T_DMA   = 3'd5;
   localparam logic [2:0] T_NONE  = 3'd6;
   localparam logic [2:0] T_CHEAT = 3'd7;

   localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
   localparam logic [15:0] ADDR_APU_LAST   = 16'h4013;
   localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
   localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
   localparam logic [15:0] ADDR_JOY1       = 16'h4016;
   localparam logic [15:0] ADDR_JOY2       = 16'h4017;
   localparam logic [15:0] ADDR_CART_BASE  = 16'h4020;

   localparam logic [2:0] PPU_STATUS   = 3'd2;
   localparam logic [2:0] PPU_OAM_DATA = 3'd4;
   localparam logic [2:0] PPU_DATA     = 3'd7;

   localparam logic [7:0] MASK_PPU_STAT_DEV = 8'hE0;
   localparam logic [7:0] MASK_PPU_STAT_OB  = 8'h1F;
   localparam logic [7:0] MASK_APU_DEV      = 8'hDF;
   localparam logic [7:0] MASK_APU_OB       = 8'h20;
   localparam logic [7:0] MASK_CTRL_DEV     = 8'h1F;
   localparam logic [7:0] MASK_CTRL_OB      = 8'hE0;

   typedef enum logic [3:0] {
      SEL_IMM,
      SEL_RAM,
      SEL_DEV,
      SEL_CPU_OB,
      SEL_PPU_OB,
      SEL_PPU_STAT,
      SEL_PPU_DEV,
      SEL_APU,
      SEL_CTRL
   } sel_type;

   typedef struct packed {
      sel_type     sel;
      logic        ppu_load;
      logic [2:0]  target;
      logic        strobe;
      logic [15:0] daddr;
      logic [7:0]  imm;
      logic [7:0]  dev;
      logic [7:0]  page;
   } acc_type;

endpackage

FILE: src/cbd_work_ram.sv
`timescale 1ns / 1ps
module cbd_work_ram #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         acc_en,
   input  logic                         acc_we,
   input  logic [$clog2(RAM_DEPTH)-1:0] acc_idx,
   input  logic [7:0]                   acc_wdata,
   output logic [7:0]                   rd_data,
   output logic                         clearing
);
   localparam int IDX_W = $clog2(RAM_DEPTH);

   logic [7:0]       mem [RAM_DEPTH];
   logic             clear_ff, clear_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [7:0]       rd_ff;
   logic             we;
   logic [IDX_W-1:0] waddr;
   logic [7:0]       wdata;

   always_comb begin
      clear_in   = clear_ff;
      clr_idx_in = clr_idx_ff;
      if (clear_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(RAM_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clear_ff   <= clear_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   assign we    = clear_ff || (acc_en && acc_we);
   assign waddr = clear_ff ? clr_idx_ff : acc_idx;
   assign wdata = clear_ff ? 8'h00 : acc_wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (acc_en && !acc_we) begin
         rd_ff <= mem[acc_idx];
      end
   end

   assign rd_data  = rd_ff;
   assign clearing = clear_ff;
endmodule

FILE: src/cbd_decode.sv
`timescale 1ns / 1ps
module cbd_decode #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cbd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               accept,
   input  logic                               in_wr,
   input  logic [15:0]                        in_addr,
   input  logic [7:0]                         in_wdata,
   input  logic [7:0]                         in_dev,
   input  logic                               b_free,
   output logic                               a_free,
   output logic                               a_move,
   output cbd_pkg::acc_type                   acc,
   output logic                               ram_we,
   output logic [$clog2(RAM_DEPTH)-1:0]       ram_idx,
   output logic [7:0]                         ram_wdata
);
   import cbd_pkg::*;

   localparam int IDX_W = $clog2(RAM_DEPTH);
   localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / RAM_DEPTH + 1);

   logic              cheat_en_ff;
   logic [15:0]       cheat_addr_ff;
   logic [7:0]        cheat_val_ff;

   logic              a_valid_ff, a_valid_in;
   logic              a_wr_ff;
   logic [15:0]       a_addr_ff;
   logic [7:0]        a_wdata_ff;
   logic [7:0]        a_dev_ff;
   logic [QUOT_W-1:0] a_quot_ff;

   logic [31:0]          prod;
   logic [RAM_WIN_W-1:0] rem;
   logic                 is_ram, is_ppu, is_cart, cheat_hit;
   logic [15:0]          fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         cheat_en_ff   <= 1'b0;
         cheat_addr_ff <= '0;
         cheat_val_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHEAT_ENABLE:  cheat_en_ff   <= csr_wdata[0];
            CSR_CHEAT_ADDRESS: cheat_addr_ff <= csr_wdata[15:0];
            CSR_CHEAT_VALUE:   cheat_val_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign a_move = a_valid_ff && b_free;
   assign a_free = !a_valid_ff || b_free;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   // quotient of the ram window by the depth, exact for a 13-bit window
   assign prod = 32'(in_addr[RAM_WIN_W-1:0]) * RECIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (accept) begin
         a_wr_ff    <= in_wr;
         a_addr_ff  <= in_addr;
         a_wdata_ff <= in_wdata;
         a_dev_ff   <= in_dev;
         a_quot_ff  <= prod[31 -: QUOT_W];
      end
   end

   assign rem     = a_addr_ff[RAM_WIN_W-1:0] - RAM_WIN_W'(a_quot_ff * RAM_DEPTH);
   assign is_ram  = a_addr_ff[15:13] == 3'b000;
   assign is_ppu  = a_addr_ff[15:13] == 3'b001;
   assign is_cart = a_addr_ff >= ADDR_CART_BASE;
   assign fold    = ADDR_PPU_BASE | {13'b0, a_addr_ff[2:0]};
   assign cheat_hit = !a_wr_ff && cheat_en_ff &&
                      (a_addr_ff == cheat_addr_ff || (is_ppu && fold == cheat_addr_ff));

   assign ram_idx   = rem[IDX_W-1:0];
   assign ram_we    = a_wr_ff && is_ram;
   assign ram_wdata = a_wdata_ff;

   always_comb begin
      acc          = '0;
      acc.dev      = a_dev_ff;
      acc.imm      = a_wdata_ff;
      acc.daddr    = is_ram ? 16'(rem[IDX_W-1:0]) : (is_ppu ? fold : a_addr_ff);
      acc.target   = T_NONE;
      acc.sel      = SEL_CPU_OB;
      if (a_wr_ff) begin
         acc.sel      = SEL_IMM;
         acc.ppu_load = is_ppu;
         if (is_ram) begin
            acc.target = T_RAM;
            acc.strobe = 1'b1;
         end else if (is_cart) begin
            acc.target = T_CART;
            acc.strobe = 1'b1;
         end else if (is_ppu) begin
            acc.target = T_PPU;
            acc.strobe = a_addr_ff[2:0] != PPU_STATUS;
         end else if (a_addr_ff <= ADDR_APU_LAST || a_addr_ff == ADDR_APU_STATUS ||
                      a_addr_ff == ADDR_JOY2) begin
            acc.target = T_APU;
            acc.strobe = 1'b1;
         end else if (a_addr_ff == ADDR_OAM_DMA) begin
            acc.target = T_DMA;
            acc.strobe = 1'b1;
            acc.page   = a_wdata_ff;
         end else if (a_addr_ff == ADDR_JOY1) begin
            acc.target = T_CTRL;
            acc.strobe = 1'b1;
         end
      end else if (cheat_hit) begin
         acc.sel    = SEL_IMM;
         acc.imm    = cheat_val_ff;
         acc.target = T_CHEAT;
      end else if (is_ram) begin
         acc.sel    = SEL_RAM;
         acc.target = T_RAM;
         acc.strobe = 1'b1;
      end else if (is_cart) begin
         acc.sel    = SEL_DEV;
         acc.target = T_CART;
         acc.strobe = 1'b1;
      end else if (is_ppu) begin
         acc.target = T_PPU;
         case (a_addr_ff[2:0])
            PPU_STATUS: begin
               acc.sel    = SEL_PPU_STAT;
               acc.strobe = 1'b1;
            end
            PPU_OAM_DATA, PPU_DATA: begin
               acc.sel    = SEL_PPU_DEV;
               acc.strobe = 1'b1;
            end
            default: acc.sel = SEL_PPU_OB;
         endcase
      end else if (a_addr_ff == ADDR_APU_STATUS) begin
         acc.sel    = SEL_APU;
         acc.target = T_APU;
         acc.strobe = 1'b1;
      end else if (a_addr_ff == ADDR_JOY1 || a_addr_ff == ADDR_JOY2) begin
         acc.sel    = SEL_CTRL;
         acc.target = T_CTRL;
         acc.strobe = 1'b1;
      end
   end
endmodule

FILE: src/cbd_respond.sv
`timescale 1ns / 1ps
module cbd_respond (
   input  logic             clock,
   input  logic             reset,
   input  logic             a_move,
   input  cbd_pkg::acc_type acc,
   input  logic [7:0]       ram_data,
   input  logic             rsp_ready,
   output logic             b_free,
   output logic             out_valid,
   output logic [7:0]       out_data,
   output logic [2:0]       out_target,
   output logic [15:0]      out_daddr,
   output logic             out_strobe,
   output logic [7:0]       out_page
);
   import cbd_pkg::*;

   logic        b_valid_ff, b_valid_in;
   acc_type     b_acc_ff;
   logic        b_move, out_free;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_data_ff;
   logic [2:0]  out_target_ff;
   logic [15:0] out_daddr_ff;
   logic        out_strobe_ff;
   logic [7:0]  out_page_ff;
   logic [7:0]  cpu_ob_ff, cpu_ob_in;
   logic [7:0]  ppu_ob_ff, ppu_ob_in;
   logic [7:0]  data;

   assign out_free = !out_valid_ff || rsp_ready;
   assign b_move   = b_valid_ff && out_free;
   assign b_free   = !b_valid_ff || out_free;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (b_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // pick the result byte: immediate, ram, device, or device bits merged with the open-bus latches
   always_comb begin
      ppu_ob_in = ppu_ob_ff;
      data      = cpu_ob_ff;
      unique case (b_acc_ff.sel)
         SEL_IMM: begin
            data = b_acc_ff.imm;
            if (b_acc_ff.ppu_load) begin
               ppu_ob_in = b_acc_ff.imm;
            end
         end
         SEL_RAM:    data = ram_data;
         SEL_DEV:    data = b_acc_ff.dev;
         SEL_CPU_OB: data = cpu_ob_ff;
         SEL_PPU_OB: data = ppu_ob_ff;
         SEL_PPU_STAT: begin
            ppu_ob_in = (b_acc_ff.dev & MASK_PPU_STAT_DEV) | (ppu_ob_ff & MASK_PPU_STAT_OB);
            data      = ppu_ob_in;
         end
         SEL_PPU_DEV: begin
            ppu_ob_in = b_acc_ff.dev;
            data      = b_acc_ff.dev;
         end
         SEL_APU:  data = (b_acc_ff.dev & MASK_APU_DEV) | (cpu_ob_ff & MASK_APU_OB);
         SEL_CTRL: data = (b_acc_ff.dev & MASK_CTRL_DEV) | (cpu_ob_ff & MASK_CTRL_OB);
         default:  data = cpu_ob_ff;
      endcase
      cpu_ob_in = data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         cpu_ob_ff    <= '0;
         ppu_ob_ff    <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (b_move) begin
            cpu_ob_ff <= cpu_ob_in;
            ppu_ob_ff <= ppu_ob_in;
         end
      end
      if (a_move) begin
         b_acc_ff <= acc;
      end
      if (b_move) begin
         out_data_ff   <= data;
         out_target_ff <= b_acc_ff.target;
         out_daddr_ff  <= b_acc_ff.daddr;
         out_strobe_ff <= b_acc_ff.strobe;
         out_page_ff   <= b_acc_ff.page;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;
   assign out_target = out_target_ff;
   assign out_daddr  = out_daddr_ff;
   assign out_strobe = out_strobe_ff;
   assign out_page   = out_page_ff;
endmodule

FILE: src/console_cpu_bus_decoder_core.sv
`timescale 1ns / 1ps
// cpu bus decoder with internal work ram and open-bus latches
// req channel: one bus access per word; tuser is the opcode (0 read, 1 write),
//   tdata carries the address, the write byte and the byte the device returns
// rsp channel: one result word per access, in order; tuser is the target code
// csr port: cheat enable, cheat address and cheat value, written by index
// an accepted access passes the decode, ram read and result registers in that order before it shows on rsp
// throughput: one access per cycle while rsp takes results and the ram clear is done; the work ram
//   has one port and takes one read or one write per access, so accesses never collide
// the pipeline has three registers (decode, ram read, result), each moves
//   on its own, so req_tready stays high while a result waits unless
//   all three are full
// reset: the latches and cheat registers clear, then a sweep zeroes the
//   work ram one byte a cycle, through every index, with req_tready low
// a stall on rsp holds the result and backs up the pipeline, never drops data
module console_cpu_bus_decoder_core #(
   parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cbd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // address, write_data, device_read_data
   input  logic                           req_tuser,  // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,  // read_data, device_address, device_strobe, dma_page
   output logic [2:0]                     rsp_tuser   // target
);
   import cbd_pkg::*;
   `include "console_cpu_bus_decoder_core_macros.svh"

   localparam int IDX_W = $clog2(RAM_DEPTH);

   logic             accept, a_free, a_move, b_free, clearing;
   acc_type          acc;
   logic             ram_we;
   logic [IDX_W-1:0] ram_idx;
   logic [7:0]       ram_wdata, ram_data;
   logic [7:0]       out_data, out_page;
   logic [15:0]      out_daddr;
   logic             out_strobe;

   assign req_tready = a_free && !clearing;
   assign accept     = req_tvalid && req_tready;

   cbd_decode #(.RAM_DEPTH(RAM_DEPTH)) u_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_wr     (req_tuser),
      .in_addr   (req_tdata[15:0]),
      .in_wdata  (req_tdata[23:16]),
      .in_dev    (req_tdata[31:24]),
      .b_free    (b_free),
      .a_free    (a_free),
      .a_move    (a_move),
      .acc       (acc),
      .ram_we    (ram_we),
      .ram_idx   (ram_idx),
      .ram_wdata (ram_wdata)
   );

   cbd_work_ram #(.RAM_DEPTH(RAM_DEPTH)) u_ram (
      .clock     (clock),
      .reset     (reset),
      .acc_en    (a_move),
      .acc_we    (ram_we),
      .acc_idx   (ram_idx),
      .acc_wdata (ram_wdata),
      .rd_data   (ram_data),
      .clearing  (clearing)
   );

   cbd_respond u_respond (
      .clock      (clock),
      .reset      (reset),
      .a_move     (a_move),
      .acc        (acc),
      .ram_data   (ram_data),
      .rsp_ready  (rsp_tready),
      .b_free     (b_free),
      .out_valid  (rsp_tvalid),
      .out_data   (out_data),
      .out_target (rsp_tuser),
      .out_daddr  (out_daddr),
      .out_strobe (out_strobe),
      .out_page   (out_page)
   );

   assign rsp_tdata = {7'b0, out_page, out_strobe, out_daddr, out_data};

   `CBD_ASSERT_ALWAYS(a_no_accept_clearing, clearing |-> !req_tready, "access taken during ram clear")
   `CBD_ASSERT(a_cheat_no_strobe, (rsp_tvalid && rsp_tuser == T_CHEAT) |-> !out_strobe, "cheat hit strobes device")
   `CBD_ASSERT(a_page_only_dma, (rsp_tvalid && out_page != 8'h00) |-> rsp_tuser == T_DMA, "dma page outside dma start")
   `CBD_ASSERT(a_ram_strobe, (rsp_tvalid && rsp_tuser == T_RAM) |-> out_strobe, "ram access without strobe")
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import cbd_pkg::*;

   localparam int RAM_WORDS   = RAM_DEPTH_DEF;
   localparam int RAM_IDX_W   = $clog2(RAM_WORDS);
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 115;
   localparam bit OP_READ     = 1'b0;
   localparam bit OP_WRITE    = 1'b1;

   typedef struct packed {
      logic [7:0]  data;
      logic [2:0]  target;
      logic [15:0] daddr;
      logic        strobe;
      logic [7:0]  page;
   } bus_result_type;

   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      bit                    op;
      logic [15:0]           addr;
      logic [7:0]            wdata;
      logic [7:0]            dev;
      bit                    known;
      bus_result_type        want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;  // address, write_data, device_read_data
   logic                  req_tuser;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;  // read_data, device_address, device_strobe, dma_page
   logic [2:0]            rsp_tuser;  // target

   // model of the block state
   logic [7:0]  work_ram_model [RAM_WORDS];
   logic [7:0]  cpu_latch;
   logic [7:0]  ppu_latch;
   logic        cheat_on;
   logic [15:0] cheat_addr;
   logic [7:0]  cheat_byte;

   bus_result_type pending_results [$];
   int             errors = 0;
   int             cycles = 0;
   int             words_seen = 0;

   int             sink_mode = 0;
   int             sink_mode_left = 0;
   int             sink_stall_left = 0;
   int             sink_hold_left = 0;
   bit             sink_hold_done = 1'b0;
   int             sink_n;
   bus_result_type sink_got;
   bus_result_type sink_want;

   console_cpu_bus_decoder_core #(.RAM_DEPTH(RAM_WORDS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bus_result_type decode_access(bit wr, logic [15:0] a, logic [7:0] wd,
                                                     logic [7:0] dv);
      bus_result_type r;
      logic           is_ram;
      logic           is_ppu;
      logic           is_cart;
      logic [15:0]    idx;
      is_ram  = a < ADDR_PPU_BASE;
      is_ppu  = a >= ADDR_PPU_BASE && a < 16'h4000;
      is_cart = a >= ADDR_CART_BASE;
      idx     = 16'(a % RAM_WORDS);
      r.daddr  = is_ram ? idx : (is_ppu ? (ADDR_PPU_BASE | {13'd0, a[2:0]}) : a);
      r.target = T_NONE;
      r.strobe = 1'b0;
      r.page   = 8'h00;
      if (wr) begin
         cpu_latch = wd;
         r.data = wd;
         if (is_ram) begin
            work_ram_model[idx[RAM_IDX_W-1:0]] = wd;
            r.target = T_RAM;
            r.strobe = 1'b1;
         end else if (is_cart) begin
            r.target = T_CART;
            r.strobe = 1'b1;
         end else if (is_ppu) begin
            ppu_latch = wd;
            r.target = T_PPU;
            r.strobe = a[2:0] != PPU_STATUS;
         end else if (a <= ADDR_APU_LAST || a == ADDR_APU_STATUS || a == ADDR_JOY2) begin
            r.target = T_APU;
            r.strobe = 1'b1;
         end else if (a == ADDR_OAM_DMA) begin
            r.target = T_DMA;
            r.strobe = 1'b1;
            r.page = wd;
         end else if (a == ADDR_JOY1) begin
            r.target = T_CTRL;
            r.strobe = 1'b1;
         end
      end else if (cheat_on && (a == cheat_addr || (is_ppu && r.daddr == cheat_addr))) begin
         cpu_latch = cheat_byte;
         r.data = cheat_byte;
         r.target = T_CHEAT;
      end else begin
         r.data = cpu_latch;
         if (is_ram) begin
            r.data = work_ram_model[idx[RAM_IDX_W-1:0]];
            r.target = T_RAM;
            r.strobe = 1'b1;
         end else if (is_cart) begin
            r.data = dv;
            r.target = T_CART;
            r.strobe = 1'b1;
         end else if (is_ppu) begin
            r.target = T_PPU;
            if (a[2:0] == PPU_STATUS) begin
               ppu_latch = (dv & MASK_PPU_STAT_DEV) | (ppu_latch & MASK_PPU_STAT_OB);
               r.strobe = 1'b1;
            end else if (a[2:0] == PPU_OAM_DATA || a[2:0] == PPU_DATA) begin
               ppu_latch = dv;
               r.strobe = 1'b1;
            end
            r.data = ppu_latch;
         end else if (a == ADDR_APU_STATUS) begin
            r.data = (dv & MASK_APU_DEV) | (cpu_latch & MASK_APU_OB);
            r.target = T_APU;
            r.strobe = 1'b1;
         end else if (a == ADDR_JOY1 || a == ADDR_JOY2) begin
            r.data = (dv & MASK_CTRL_DEV) | (cpu_latch & MASK_CTRL_OB);
            r.target = T_CTRL;
            r.strobe = 1'b1;
         end
         cpu_latch = r.data;
      end
      return r;
   endfunction

   function automatic plan_row_type acc(bit op, logic [15:0] a, logic [7:0] wd,
                                        logic [7:0] dv);
      plan_row_type p;
      p = '{default: '0};
      p.op = op;
      p.addr = a;
      p.wdata = wd;
      p.dev = dv;
      return p;
   endfunction

   function automatic plan_row_type acc_k(bit op, logic [15:0] a, logic [7:0] wd,
                                          logic [7:0] dv, bus_result_type want);
      plan_row_type p;
      p = acc(op, a, wd, dv);
      p.known = 1'b1;
      p.want = want;
      return p;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] val);
      plan_row_type p;
      p = '{default: '0};
      p.is_reg = 1'b1;
      p.reg_idx = idx;
      p.reg_val = val;
      return p;
   endfunction

   // no gap in mode 0, no gap or a short one in mode 1, else mostly none, some short, a few long
   function automatic int gap_len(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0 || r < 50) return 0;
      if (mode == 1 || r < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      // ram: a few hot bytes so reads return earlier writes, any mirror
      if (r < 30)
         return 16'(($urandom_range(0, 3) << 11) |
                    ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 2047)));
      if (r < 55) return ADDR_PPU_BASE | 16'($urandom_range(0, 16'h1FFF));
      if (r < 75) return 16'h4000 + 16'($urandom_range(0, 31));
      if (r < 95) return 16'($urandom_range(ADDR_CART_BASE, 16'hFFFF));
      return cheat_addr;
   endfunction

   task automatic send_access(bit op, logic [15:0] a, logic [7:0] wd, logic [7:0] dv,
                              bit known, bus_result_type want);
      bus_result_type r;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {dv, wd, a};
      do @(posedge clock); while (!req_tready);
      r = decode_access(op, a, wd, dv);
      pending_results.push_back(known ? want : r);
   endtask

   task automatic idle_req(int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         req_tuser <= 1'($urandom_range(0, 1));
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CHEAT_ENABLE:  cheat_on = val[0];
         CSR_CHEAT_ADDRESS: cheat_addr = val;
         CSR_CHEAT_VALUE:   cheat_byte = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      plan_row_type   plan [$];
      bus_result_type none;
      int             gap_mode;
      bit             op;
      logic [15:0]    a;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      none = '0;
      foreach (work_ram_model[i]) work_ram_model[i] = 8'h00;
      cpu_latch = 8'h00;
      ppu_latch = 8'h00;
      cheat_on = 1'b0;
      cheat_addr = 16'h0000;
      cheat_byte = 8'h00;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = '{
         acc_k(OP_READ, 16'h0000, 8'h00, 8'hFF, '{8'h00, T_RAM, 16'h0000, 1'b1, 8'h00}),
         acc_k(OP_READ, 16'hFFFF, 8'h00, 8'hFF, '{8'hFF, T_CART, 16'hFFFF, 1'b1, 8'h00}),
         acc(OP_WRITE, 16'h07FF, 8'hFF, 8'h00),
         acc(OP_READ, 16'h1FFF, 8'h00, 8'h00),
         acc(OP_WRITE, 16'h0800, 8'h5A, 8'h00),
         acc(OP_READ, 16'h0000, 8'h00, 8'h00),
         acc(OP_WRITE, 16'h2000, 8'hA5, 8'h00),
         acc(OP_READ, 16'h2005, 8'h00, 8'hFF),
         acc(OP_READ, 16'h3FFA, 8'h00, 8'hFF),
         acc(OP_READ, 16'h2004, 8'h00, 8'h3C),
         acc(OP_READ, 16'h3FFF, 8'h00, 8'h81),
         acc(OP_WRITE, 16'h2002, 8'h55, 8'h00),
         acc(OP_READ, ADDR_APU_STATUS, 8'h00, 8'hFF),
         acc(OP_READ, ADDR_JOY1, 8'h00, 8'h00),
         acc(OP_READ, ADDR_JOY2, 8'h00, 8'hFF),
         acc(OP_READ, ADDR_OAM_DMA, 8'h00, 8'hFF),
         acc(OP_WRITE, ADDR_APU_LAST, 8'h01, 8'h00),
         acc(OP_WRITE, ADDR_APU_STATUS, 8'h0F, 8'h00),
         acc_k(OP_WRITE, ADDR_OAM_DMA, 8'hFF, 8'h00,
               '{8'hFF, T_DMA, ADDR_OAM_DMA, 1'b1, 8'hFF}),
         acc(OP_WRITE, ADDR_JOY1, 8'h01, 8'h00),
         acc(OP_WRITE, 16'h401F, 8'h00, 8'h00),
         acc(OP_WRITE, ADDR_CART_BASE, 8'h80, 8'h00),
         reg_row(CSR_CHEAT_ENABLE, 16'd1),
         reg_row(CSR_CHEAT_ADDRESS, 16'h2002),
         reg_row(CSR_CHEAT_VALUE, 16'h00C3),
         acc(OP_READ, 16'h3FFA, 8'h00, 8'h00),
         acc_k(OP_READ, 16'h2002, 8'h00, 8'h00, '{8'hC3, T_CHEAT, 16'h2002, 1'b0, 8'h00}),
         acc(OP_WRITE, 16'h2002, 8'h11, 8'h00),
         reg_row(CSR_CHEAT_ADDRESS, 16'hFFFF),
         reg_row(CSR_CHEAT_VALUE, 16'h00FF),
         acc(OP_READ, 16'hFFFF, 8'h00, 8'h00)
      };

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            wait_idle();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_access(plan[i].op, plan[i].addr, plan[i].wdata, plan[i].dev,
                        plan[i].known, plan[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_reg(CSR_CHEAT_ENABLE, 16'd0);
               write_reg(CSR_CHEAT_ADDRESS, 16'h0000);
               write_reg(CSR_CHEAT_VALUE, 16'h0000);
            end
            1: begin
               write_reg(CSR_CHEAT_ENABLE, 16'd1);
               write_reg(CSR_CHEAT_ADDRESS, 16'hFFFF);
               write_reg(CSR_CHEAT_VALUE, 16'h00FF);
            end
            2: begin
               write_reg(CSR_CHEAT_ENABLE, 16'd1);
               write_reg(CSR_CHEAT_ADDRESS, ADDR_PPU_BASE | 16'($urandom_range(0, 7)));
               write_reg(CSR_CHEAT_VALUE, 16'($urandom_range(0, 255)));
            end
            default: begin
               write_reg(CSR_CHEAT_ENABLE, 16'($urandom_range(0, 9) < 7));
               write_reg(CSR_CHEAT_ADDRESS, $urandom_range(0, 1) ? pick_address() :
                                            16'($urandom_range(0, 16'hFFFF)));
               write_reg(CSR_CHEAT_VALUE, 16'($urandom_range(0, 255)));
            end
         endcase
         gap_mode = $urandom_range(0, 2);
         repeat (PHASE_WORDS) begin
            op = 1'($urandom_range(0, 1));
            a = pick_address();
            send_access(op, a, rand_byte(), rand_byte(), 1'b0, none);
            idle_req(gap_len(gap_mode));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // result side ready: random stalls, one long hold to back up the pipeline
   always @(negedge clock) begin
      if (sink_hold_left > 0) begin
         sink_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!sink_hold_done && words_seen >= 400) begin
         sink_hold_done = 1'b1;
         sink_hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if (sink_mode_left == 0) begin
            sink_mode = $urandom_range(0, 2);
            sink_mode_left = $urandom_range(50, 300);
         end else begin
            sink_mode_left--;
         end
         if (sink_stall_left > 0) begin
            sink_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            sink_n = ($urandom_range(0, 3) == 0) ? gap_len(sink_mode) : 0;
            if (sink_n > 0) begin
               sink_stall_left = sink_n - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sink_got = {rsp_tdata[7:0], rsp_tuser, rsp_tdata[23:8], rsp_tdata[24],
                     rsp_tdata[32:25]};
         words_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected: %h", $time, sink_got);
            errors++;
         end else begin
            sink_want = pending_results.pop_front();
            if (sink_got !== sink_want) begin
               errors++;
               if (sink_got.data !== sink_want.data)
                  $display("%0t: read_data expected %h got %h", $time, sink_want.data,
                           sink_got.data);
               if (sink_got.target !== sink_want.target)
                  $display("%0t: target expected %0d got %0d", $time, sink_want.target,
                           sink_got.target);
               if (sink_got.daddr !== sink_want.daddr)
                  $display("%0t: device_address expected %h got %h", $time, sink_want.daddr,
                           sink_got.daddr);
               if (sink_got.strobe !== sink_want.strobe)
                  $display("%0t: device_strobe expected %b got %b", $time, sink_want.strobe,
                           sink_got.strobe);
               if (sink_got.page !== sink_want.page)
                  $display("%0t: dma_page expected %h got %h", $time, sink_want.page,
                           sink_got.page);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

endmodule
